FILE: rtl/core/tcch_pkg.sv
// Shared types, constants and tables of the tilt-compensated compass heading block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package tcch_pkg;

    localparam int SqrtSteps   = 30;
    localparam int CordicSteps = 20;
    localparam int RadW        = 2 * SqrtSteps;
    localparam int RemW        = SqrtSteps + 4;
    localparam int CxW         = 43;
    localparam int CzW         = 25;
    localparam int IdxW        = 5;

    localparam logic [2:0] CfgMinX = 3'd0;
    localparam logic [2:0] CfgMinY = 3'd1;
    localparam logic [2:0] CfgMinZ = 3'd2;
    localparam logic [2:0] CfgMaxX = 3'd3;
    localparam logic [2:0] CfgMaxY = 3'd4;
    localparam logic [2:0] CfgMaxZ = 3'd5;

    localparam logic [24:0] FullTurn    = 25'd23592960;
    localparam logic [24:0] HalfTurn    = 25'd11796480;
    localparam logic [22:0] QuarterTurn = 23'd5898240;
    localparam logic [24:0] RoundBias   = 25'd512;
    localparam logic [14:0] HeadingWrap = 15'd23040;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic signed [15:0] acc_x;
        logic signed [15:0] acc_y;
        logic signed [15:0] acc_z;
    } t_in;

    typedef struct packed {
        logic [14:0] heading_q6;
        logic        invalid;
    } t_out;

    typedef struct packed {
        logic        exneg;
        logic        nxneg;
        logic        inv;
        logic        zz;
    } t_tag;

    typedef struct packed {
        logic [32:0] exmag;
        logic [48:0] nxmag;
        t_tag        tag;
    } t_side;

    function automatic logic signed [CzW-1:0] atan_tab(input logic [IdxW-1:0] idx);
        logic signed [CzW-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/tcch_sqrt_cell.sv
// One cell of the pipelined square-root chain: one result bit per cell.
// Depends on tcch_pkg.
`timescale 1ns / 1ps

module tcch_sqrt_cell import tcch_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [RadW-1:0]      i_rad,
    input  logic [RemW-1:0]      i_rem,
    input  logic [SqrtSteps-1:0] i_root,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [RadW-1:0]      o_rad,
    output logic [RemW-1:0]      o_rem,
    output logic [SqrtSteps-1:0] o_root,
    output t_side                o_side
);

    logic [RemW-1:0] w_wr;
    logic [RemW-1:0] w_tr;
    logic            w_ge;

    assign w_wr = {i_rem[RemW-3:0], i_rad[RadW-1 -: 2]};
    assign w_tr = {2'b00, i_root, 2'b01};
    assign w_ge = (w_wr >= w_tr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_rad  <= {i_rad[RadW-3:0], 2'b00};
            o_rem  <= w_ge ? (w_wr - w_tr) : w_wr;
            o_root <= {i_root[SqrtSteps-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

FILE: rtl/core/tcch_cordic_cell.sv
// One vectoring CORDIC cell: one micro-rotation per cell, registered.
// Depends on tcch_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module tcch_cordic_cell import tcch_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [IdxW-1:0]       i_idx,
    input  logic                  i_valid,
    input  logic signed [CxW-1:0] i_x,
    input  logic signed [CxW-1:0] i_y,
    input  logic signed [CzW-1:0] i_z,
    input  t_tag                  i_tag,
    output logic                  o_valid,
    output logic signed [CxW-1:0] o_x,
    output logic signed [CxW-1:0] o_y,
    output logic signed [CzW-1:0] o_z,
    output t_tag                  o_tag
);

    logic signed [CxW-1:0] w_dx;
    logic signed [CxW-1:0] w_dy;
    logic signed [CzW-1:0] w_at;

    assign w_dx = i_y >>> i_idx;
    assign w_dy = i_x >>> i_idx;
    assign w_at = atan_tab(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            if (!i_y[CxW-1]) begin
                o_x <= i_x + w_dx;
                o_y <= i_y - w_dy;
                o_z <= i_z + w_at;
            end else begin
                o_x <= i_x - w_dx;
                o_y <= i_y + w_dy;
                o_z <= i_z - w_at;
            end
            o_tag <= i_tag;
        end
    end

endmodule

FILE: rtl/core/tilt_compensated_compass_heading_top.sv
// Top level of the tilt-compensated compass heading block.
// Depends on tcch_pkg, tcch_sqrt_cell and tcch_cordic_cell.
//
// Input channel i_in_valid / o_in_ready carries one item: raw magnetometer and
// accelerometer vectors. Output channel o_out_valid / i_out_ready carries the
// heading in 1/64 degree and an invalid flag, one result per item, in order.
// Calibration minima and maxima are written through i_cfg_we / i_cfg_idx /
// i_cfg_data by the user only while the block is idle; the block does not
// enforce this. Indexes above five are ignored. Throughput: one item per cycle
// while the output is not stalled. Each item passes five front-end stages
// (offset, cross products, norm), a 30-cell square-root chain, four scaling
// and normalising stages, a 20-cell CORDIC chain, a final quadrant stage and
// the output register. Reset clears the calibration registers to zero and
// empties the pipeline. When the receiver stalls, one more item moves into a
// skid register and the pipeline then holds until the output is taken.
`timescale 1ns / 1ps

module tilt_compensated_compass_heading_top import tcch_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic signed [15:0] r_cfg [0:5];
    logic               w_en;

    // front end
    logic signed [15:0] w_m [0:2];
    logic signed [15:0] w_a [0:2];
    logic signed [16:0] w_s [0:2];
    logic signed [16:0] w_off [0:2];
    logic signed [17:0] n1_t [0:2];

    logic               r1_v;
    logic signed [17:0] r1_t [0:2];
    logic signed [15:0] r1_a [0:2];
    logic               r2_v;
    logic signed [33:0] r2_p [0:5];
    logic signed [15:0] r2_a [0:2];
    logic               r3_v;
    logic signed [33:0] r3_e [0:2];
    logic signed [15:0] r3_a [0:2];
    logic               r4_v;
    logic signed [49:0] r4_q1;
    logic signed [49:0] r4_q2;
    logic signed [31:0] r4_sq [0:2];
    logic signed [33:0] r4_ex;
    logic               r4_ez;
    logic signed [49:0] n5_nx;
    logic signed [33:0] n5_exabs;
    logic signed [49:0] n5_nxabs;
    logic [31:0]        n5_a2;
    logic               r5_v;
    logic [RadW-1:0]    r5_rad;
    t_side              r5_side;

    // square-root chain
    logic                 w_sq_v    [0:SqrtSteps];
    logic [RadW-1:0]      w_sq_rad  [0:SqrtSteps];
    logic [RemW-1:0]      w_sq_rem  [0:SqrtSteps];
    logic [SqrtSteps-1:0] w_sq_root [0:SqrtSteps];
    t_side                w_sq_side [0:SqrtSteps];

    // scaling and normalisation
    logic        r6_v;
    logic [46:0] r6_p0;
    logic [45:0] r6_p1;
    logic [63:0] r6_ux;
    t_tag        r6_tag;
    logic        r7_v;
    logic [63:0] r7_ux;
    logic [63:0] r7_uy;
    t_tag        r7_tag;
    logic [63:0] n8_x;
    logic [63:0] n8_y;
    logic        r8_v;
    logic [63:0] r8_x;
    logic [63:0] r8_y;
    t_tag        r8_tag;
    logic [63:0] n9_x;
    logic [63:0] n9_y;
    logic        r9_v;
    logic [39:0] r9_x;
    logic [39:0] r9_y;
    t_tag        r9_tag;

    // CORDIC chain
    logic                  w_co_v   [0:CordicSteps];
    logic signed [CxW-1:0] w_co_x   [0:CordicSteps];
    logic signed [CxW-1:0] w_co_y   [0:CordicSteps];
    logic signed [CzW-1:0] w_co_z   [0:CordicSteps];
    t_tag                  w_co_tag [0:CordicSteps];

    // final stage and output
    logic [22:0] w_zc;
    logic [24:0] w_h;
    logic [24:0] w_hr;
    logic [14:0] w_q;
    t_out        n10_d;
    logic        r10_v;
    t_out        r10_d;
    logic        r_ov;
    t_out        r_od;
    logic        r_sv;
    t_out        r_sd;

    assign w_en        = !r_sv;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_ov;
    assign o_out       = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_cfg[k] <= 16'sd0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgMinX: r_cfg[0] <= i_cfg_data;
                CfgMinY: r_cfg[1] <= i_cfg_data;
                CfgMinZ: r_cfg[2] <= i_cfg_data;
                CfgMaxX: r_cfg[3] <= i_cfg_data;
                CfgMaxY: r_cfg[4] <= i_cfg_data;
                CfgMaxZ: r_cfg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_m[0] = i_in.mag_x;
    assign w_m[1] = i_in.mag_y;
    assign w_m[2] = i_in.mag_z;
    assign w_a[0] = i_in.acc_x;
    assign w_a[1] = i_in.acc_y;
    assign w_a[2] = i_in.acc_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_s[k]   = $signed({r_cfg[k][15], r_cfg[k]}) +
                       $signed({r_cfg[k+3][15], r_cfg[k+3]});
            w_off[k] = (w_s[k] + $signed({16'b0, w_s[k][16]})) >>> 1;
            n1_t[k]  = $signed({w_m[k][15], w_m[k][15], w_m[k]}) -
                       $signed({w_off[k][16], w_off[k]});
        end
    end

    always_comb begin
        n5_nx    = r4_q1 - r4_q2;
        n5_exabs = r4_ex[33] ? -r4_ex : r4_ex;
        n5_nxabs = n5_nx[49] ? -n5_nx : n5_nx;
        n5_a2    = {1'b0, r4_sq[0][30:0]} + {1'b0, r4_sq[1][30:0]} +
                   {1'b0, r4_sq[2][30:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_t[k] <= n1_t[k];
                r1_a[k] <= w_a[k];
                r2_a[k] <= r1_a[k];
                r3_a[k] <= r2_a[k];
                r4_sq[k] <= r3_a[k] * r3_a[k];
            end
            r2_p[0] <= r1_t[1] * r1_a[2];
            r2_p[1] <= r1_t[2] * r1_a[1];
            r2_p[2] <= r1_t[2] * r1_a[0];
            r2_p[3] <= r1_t[0] * r1_a[2];
            r2_p[4] <= r1_t[0] * r1_a[1];
            r2_p[5] <= r1_t[1] * r1_a[0];
            r3_e[0] <= r2_p[0] - r2_p[1];
            r3_e[1] <= r2_p[2] - r2_p[3];
            r3_e[2] <= r2_p[4] - r2_p[5];
            r4_q1   <= r3_a[1] * r3_e[2];
            r4_q2   <= r3_a[2] * r3_e[1];
            r4_ex   <= r3_e[0];
            r4_ez   <= (r3_e[0] == 34'sd0) && (r3_e[1] == 34'sd0) && (r3_e[2] == 34'sd0);
            r5_rad  <= {n5_a2[RadW-29:0], 28'b0};
            r5_side.exmag     <= n5_exabs[32:0];
            r5_side.nxmag     <= n5_nxabs[48:0];
            r5_side.tag.exneg <= r4_ex[33];
            r5_side.tag.nxneg <= n5_nx[49];
            r5_side.tag.inv   <= r4_ez;
            r5_side.tag.zz    <= (r4_ex == 34'sd0) && (n5_nx == 50'sd0);
        end
    end

    assign w_sq_v[0]    = r5_v;
    assign w_sq_rad[0]  = r5_rad;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_side[0] = r5_side;

    for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
        tcch_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v[g]),
            .i_rad   (w_sq_rad[g]),
            .i_rem   (w_sq_rem[g]),
            .i_root  (w_sq_root[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_rad   (w_sq_rad[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    always_comb begin
        n8_x = r7_ux;
        n8_y = r7_uy;
        if ((n8_x[63:32] | n8_y[63:32]) == 32'd0) begin
            n8_x = {n8_x[31:0], 32'd0};
            n8_y = {n8_y[31:0], 32'd0};
        end
        if ((n8_x[63:48] | n8_y[63:48]) == 16'd0) begin
            n8_x = {n8_x[47:0], 16'd0};
            n8_y = {n8_y[47:0], 16'd0};
        end
        if ((n8_x[63:56] | n8_y[63:56]) == 8'd0) begin
            n8_x = {n8_x[55:0], 8'd0};
            n8_y = {n8_y[55:0], 8'd0};
        end
        n9_x = r8_x;
        n9_y = r8_y;
        if ((n9_x[63:60] | n9_y[63:60]) == 4'd0) begin
            n9_x = {n9_x[59:0], 4'd0};
            n9_y = {n9_y[59:0], 4'd0};
        end
        if ((n9_x[63:62] | n9_y[63:62]) == 2'd0) begin
            n9_x = {n9_x[61:0], 2'd0};
            n9_y = {n9_y[61:0], 2'd0};
        end
        if ((n9_x[63] | n9_y[63]) == 1'b0) begin
            n9_x = {n9_x[62:0], 1'b0};
            n9_y = {n9_y[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= w_sq_v[SqrtSteps];
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
        if (w_en) begin
            r6_p0  <= w_sq_side[SqrtSteps].exmag[16:0] * w_sq_root[SqrtSteps];
            r6_p1  <= w_sq_side[SqrtSteps].exmag[32:17] * w_sq_root[SqrtSteps];
            r6_ux  <= {1'b0, w_sq_side[SqrtSteps].nxmag, 14'd0};
            r6_tag <= w_sq_side[SqrtSteps].tag;
            r7_ux  <= r6_ux;
            r7_uy  <= {17'd0, r6_p0} + {1'b0, r6_p1, 17'd0};
            r7_tag <= r6_tag;
            r8_x   <= n8_x;
            r8_y   <= n8_y;
            r8_tag <= r7_tag;
            r9_x   <= n9_x[63:24];
            r9_y   <= n9_y[63:24];
            r9_tag <= r8_tag;
        end
    end

    assign w_co_v[0]   = r9_v;
    assign w_co_x[0]   = $signed({3'b000, r9_x});
    assign w_co_y[0]   = $signed({3'b000, r9_y});
    assign w_co_z[0]   = '0;
    assign w_co_tag[0] = r9_tag;

    for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
        tcch_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (IdxW'(g)),
            .i_valid (w_co_v[g]),
            .i_x     (w_co_x[g]),
            .i_y     (w_co_y[g]),
            .i_z     (w_co_z[g]),
            .i_tag   (w_co_tag[g]),
            .o_valid (w_co_v[g+1]),
            .o_x     (w_co_x[g+1]),
            .o_y     (w_co_y[g+1]),
            .o_z     (w_co_z[g+1]),
            .o_tag   (w_co_tag[g+1])
        );
    end

    always_comb begin
        if (w_co_z[CordicSteps][CzW-1]) begin
            w_zc = 23'd0;
        end else if (w_co_z[CordicSteps][CzW-2:0] > {1'b0, QuarterTurn}) begin
            w_zc = QuarterTurn;
        end else begin
            w_zc = w_co_z[CordicSteps][22:0];
        end
        case ({w_co_tag[CordicSteps].nxneg, w_co_tag[CordicSteps].exneg})
            2'b00:   w_h = {2'b00, w_zc};
            2'b01:   w_h = FullTurn - {2'b00, w_zc};
            2'b10:   w_h = HalfTurn - {2'b00, w_zc};
            default: w_h = HalfTurn + {2'b00, w_zc};
        endcase
        w_hr = w_h + RoundBias;
        w_q  = (w_hr[24:10] == HeadingWrap) ? 15'd0 : w_hr[24:10];
        n10_d.invalid    = w_co_tag[CordicSteps].inv;
        if (w_co_tag[CordicSteps].inv || w_co_tag[CordicSteps].zz) begin
            n10_d.heading_q6 = 15'd0;
        end else begin
            n10_d.heading_q6 = w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            if (w_en) begin
                r10_v <= w_co_v[CordicSteps];
            end
            if (!r_ov || i_out_ready) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= r10_v;
                end
            end else if (w_en && r10_v) begin
                r_sv <= 1'b1;
            end
        end
        if (w_en) begin
            r10_d <= n10_d;
        end
        if (!r_ov || i_out_ready) begin
            r_od <= r_sv ? r_sd : r10_d;
        end else if (w_en && r10_v) begin
            r_sd <= r10_d;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid item held without an output item");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready && !r_sv && r10_v) |=> r_sv)
        else $error("stalled result lost instead of entering skid");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_od.invalid) |-> (r_od.heading_q6 == 15'd0))
        else $error("invalid result carries a nonzero heading");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od.heading_q6 < HeadingWrap))
        else $error("heading out of range");

endmodule
